// ===== rtl/cwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cwm_pkg;

  localparam int DEPTH  = 1024;
  localparam int RAM_AW = $clog2(DEPTH);
  localparam int ADDR_W = 10;
  localparam int SIZE_W = 11;
  localparam int WORD_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  localparam logic [1:0] FN_READ  = 2'd0;
  localparam logic [1:0] FN_WRITE = 2'd1;
  localparam logic [1:0] FN_ADD   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_UNWRITTEN = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              acc_load;
  } unit_ctrl_t;

  typedef struct packed {
    logic              in_range;
    logic [WORD_W-1:0] sum;
  } unit_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cwm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/cwm_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cwm_unit
  import cwm_pkg::*;
(
  input  wire logic              clk,
  input  wire unit_ctrl_t        ctrl,
  input  wire logic [SIZE_W-1:0] mem_size,
  input  wire logic [WORD_W-1:0] operand,
  output unit_stat_t             stat
);

  logic [WORD_W-1:0] acc;
  logic [SIZE_W-1:0] lim;

  // Sizes above the memory depth behave as the full depth.
  assign lim = (mem_size > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : mem_size;

  assign stat.in_range = SIZE_W'(ctrl.addr) < lim;
  assign stat.sum      = acc + operand;

  always_ff @(posedge clk) begin
    if (ctrl.acc_load) begin
      acc <= operand;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/checked_word_memory_with_add_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Fields (lowest bit first)
// s_axis     in   tuser: func; tdata: addr_a, addr_b, addr_dest, value, 2 pad bits
// m_axis     out  tuser: status; tdata: read_data
// cfg        in   cfg_wdata: mem_size, written when cfg_wen is high
//
// After reset a clearing pass over every row wipes the written marks; no
// transfer is accepted until it ends. A request runs S_CHECK then S_DONE
// (write, undefined op, or a read or add whose first address is out of
// range), S_CHECK, S_WAIT_A, S_DONE (read, or an add that fails on its first
// operand or on the range of its second) or S_CHECK, S_WAIT_A, S_WAIT_B, S_DONE
// (add), set by the single read port of the cell memory, which the add uses twice.
// A stalled result holds in the output register while the next request runs;
// that request's result then waits in the block until the register frees.

module checked_word_memory_with_add_unit
  import cwm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [63:0]       s_axis_tdata,  // addr_a, addr_b, addr_dest, value, pad
  input  wire logic [1:0]        s_axis_tuser,  // func
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [WORD_W-1:0]      m_axis_tdata,  // read_data
  output logic [1:0]             m_axis_tuser   // status
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_WAIT_A = 3'd3;
  localparam logic [2:0] S_WAIT_B = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state;
  logic [RAM_AW-1:0] clr_addr;
  logic [SIZE_W-1:0] mem_size;
  logic [1:0]        func;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [ADDR_W-1:0] addr_dest;
  logic [WORD_W-1:0] value;
  logic [WORD_W-1:0] res_data;
  logic [1:0]        res_status;
  logic              out_load;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [WORD_W:0]   ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [WORD_W:0]   ram_rdata;
  logic              cell_written;

  unit_ctrl_t uctrl;
  unit_stat_t ustat;

  // Each memory row holds the written mark above the data word.
  cwm_ram #(
    .WIDTH(WORD_W + 1),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  cwm_unit u_unit (
    .clk     (clk),
    .ctrl    (uctrl),
    .mem_size(mem_size),
    .operand (ram_rdata[WORD_W-1:0]),
    .stat    (ustat)
  );

  assign cell_written  = ram_rdata[WORD_W];
  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_raddr = (state == S_WAIT_A) ? RAM_AW'(addr_b) : RAM_AW'(addr_a);
    uctrl.acc_load = (state == S_WAIT_A);
    case (state)
      S_CHECK:  uctrl.addr = addr_a;
      S_WAIT_A: uctrl.addr = addr_b;
      default:  uctrl.addr = addr_dest;
    endcase
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_CHECK: begin
        if (func == FN_WRITE && ustat.in_range) begin
          ram_we    = 1'b1;
          ram_waddr = RAM_AW'(addr_a);
          ram_wdata = {1'b1, value};
        end
      end
      S_WAIT_B: begin
        if (cell_written && ustat.in_range) begin
          ram_we    = 1'b1;
          ram_waddr = RAM_AW'(addr_dest);
          ram_wdata = {1'b1, ustat.sum};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      mem_size      <= SIZE_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        mem_size <= cfg_wdata;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= RAM_AW'(clr_addr + 1'b1);
          if (clr_addr == RAM_AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func      <= s_axis_tuser;
            addr_a    <= s_axis_tdata[9:0];
            addr_b    <= s_axis_tdata[19:10];
            addr_dest <= s_axis_tdata[29:20];
            value     <= s_axis_tdata[61:30];
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_data <= '0;
          case (func)
            FN_READ, FN_ADD: begin
              if (!ustat.in_range) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_WAIT_A;
              end
            end
            FN_WRITE: begin
              res_status <= ustat.in_range ? ST_OK : ST_RANGE;
              state      <= S_DONE;
            end
            default: begin
              res_status <= ST_OK;
              state      <= S_DONE;
            end
          endcase
        end
        S_WAIT_A: begin
          if (!cell_written) begin
            res_status <= ST_UNWRITTEN;
            state      <= S_DONE;
          end else if (func == FN_READ) begin
            res_data <= ram_rdata[WORD_W-1:0];
            state    <= S_DONE;
          end else if (!ustat.in_range) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_WAIT_B;
          end
        end
        S_WAIT_B: begin
          state <= S_DONE;
          if (!cell_written) begin
            res_status <= ST_UNWRITTEN;
          end else if (!ustat.in_range) begin
            res_status <= ST_RANGE;
          end else begin
            res_data <= ustat.sum;
          end
        end
        S_DONE: begin
          if (out_load) begin
            m_axis_tdata <= res_data;
            m_axis_tuser <= res_status;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A failed or data-less request never returns a nonzero word.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("error result carries nonzero data");

  // Only one request is in flight: acceptance closes the input at once.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a request is in progress");

  // The memory is never written while the block waits for a request.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !ram_we)
    else $error("memory write outside request processing");

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== sim/checked_word_memory_with_add_unit_tb.sv =====
`timescale 1ns / 1ps

module checked_word_memory_with_add_unit_tb;
  import cwm_pkg::*;

  localparam logic [1:0] FN_UNDEF = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_dest;
    logic [WORD_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [1:0]        status;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;  // addr_a, addr_b, addr_dest, value, pad
  logic [1:0]        s_axis_tuser = '0;  // func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [WORD_W-1:0] m_axis_tdata;       // read_data
  logic [1:0]        m_axis_tuser;       // status

  checked_word_memory_with_add_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [WORD_W-1:0] cell_words [DEPTH];
  bit                cell_marks [DEPTH];
  logic [SIZE_W-1:0] used_size = SIZE_RESET;

  request_t request_queue [$];
  answer_t  pending_answers [$];
  request_t next_req;
  request_t seen_req;
  answer_t  seen_answer;
  answer_t  oldest_answer;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       mismatches = 0;

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int size_limit();
    return (used_size > DEPTH) ? DEPTH : int'(used_size);
  endfunction

  function automatic logic [1:0] read_status(input logic [ADDR_W-1:0] addr);
    if (int'(addr) >= size_limit()) return ST_RANGE;
    return cell_marks[addr] ? ST_OK : ST_UNWRITTEN;
  endfunction

  function automatic logic [1:0] write_status(input logic [ADDR_W-1:0] addr);
    return (int'(addr) < size_limit()) ? ST_OK : ST_RANGE;
  endfunction

  task automatic apply_request(input request_t rq, output answer_t ans);
    ans = '0;
    case (rq.func)
      FN_READ: begin
        ans.status = read_status(rq.addr_a);
        if (ans.status == ST_OK) ans.data = cell_words[rq.addr_a];
      end
      FN_WRITE: begin
        ans.status = write_status(rq.addr_a);
        if (ans.status == ST_OK) begin
          cell_words[rq.addr_a] = rq.value;
          cell_marks[rq.addr_a] = 1'b1;
        end
      end
      FN_ADD: begin
        ans.status = read_status(rq.addr_a);
        if (ans.status == ST_OK) ans.status = read_status(rq.addr_b);
        if (ans.status == ST_OK) ans.status = write_status(rq.addr_dest);
        if (ans.status == ST_OK) begin
          ans.data = cell_words[rq.addr_a] + cell_words[rq.addr_b];
          cell_words[rq.addr_dest] = ans.data;
          cell_marks[rq.addr_dest] = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = request_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= next_req.func;
        s_axis_tdata <= {2'b00, next_req.value, next_req.addr_dest, next_req.addr_b,
                         next_req.addr_a};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result transfer with none pending", m_axis_tdata, '0);
        end else begin
          oldest_answer = pending_answers.pop_front();
          if (m_axis_tdata !== oldest_answer.data)
            report_mismatch("read_data", m_axis_tdata, oldest_answer.data);
          if (m_axis_tuser !== oldest_answer.status)
            report_mismatch("status", WORD_W'(m_axis_tuser), WORD_W'(oldest_answer.status));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_req.func = s_axis_tuser;
        seen_req.addr_a = s_axis_tdata[9:0];
        seen_req.addr_b = s_axis_tdata[19:10];
        seen_req.addr_dest = s_axis_tdata[29:20];
        seen_req.value = s_axis_tdata[61:30];
        apply_request(seen_req, seen_answer);
        pending_answers.push_back(seen_answer);
      end
    end
  end

  task automatic queue_req(input logic [1:0] func, input int a, input int b, input int d,
                           input logic [WORD_W-1:0] value);
    request_t rq;
    rq.func = func;
    rq.addr_a = ADDR_W'(a);
    rq.addr_b = ADDR_W'(b);
    rq.addr_dest = ADDR_W'(d);
    rq.value = value;
    request_queue.push_back(rq);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (request_queue.size() != 0 || s_axis_tvalid || pending_answers.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] new_size);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= new_size;
    @(posedge clk);
    cfg_wen <= 1'b0;
    used_size = new_size;
  endtask

  function automatic int pick_addr();
    int lim;
    int r;
    lim = size_limit();
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 12) return $urandom_range(0, DEPTH - 1);
    if (r < 24) return (lim - 1 + $urandom_range(0, 2)) % DEPTH;
    return $urandom_range(0, ((lim < 16) ? lim : 16) - 1);
  endfunction

  task automatic queue_random_req();
    int r;
    logic [1:0] func;
    r = $urandom_range(0, 99);
    if (r < 30) func = FN_WRITE;
    else if (r < 60) func = FN_READ;
    else if (r < 95) func = FN_ADD;
    else func = FN_UNDEF;
    queue_req(func, pick_addr(), pick_addr(), pick_addr(), $urandom());
  endtask

  int seg_sizes [8];
  int seg_items [8];

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting at the reset size.
    queue_req(FN_READ, 0, 0, 0, '0);
    queue_req(FN_WRITE, 0, 0, 0, 32'h7fff_ffff);
    queue_req(FN_WRITE, 1023, 0, 0, 32'h8000_0000);
    queue_req(FN_READ, 0, 0, 0, '0);
    queue_req(FN_READ, 1023, 0, 0, '0);
    queue_req(FN_ADD, 0, 1023, 5, '0);
    queue_req(FN_ADD, 0, 0, 0, '0);
    queue_req(FN_READ, 0, 0, 0, '0);
    queue_req(FN_ADD, 3, 0, 1, '0);
    queue_req(FN_ADD, 0, 7, 1, '0);
    queue_req(FN_UNDEF, 1023, 1023, 1023, 32'hffff_ffff);
    queue_req(FN_WRITE, 1023, 0, 0, 32'hffff_ffff);
    queue_req(FN_ADD, 1023, 1023, 1023, '0);
    wait_idle();
    write_size(SIZE_W'(4));
    queue_req(FN_READ, 1023, 0, 0, '0);
    queue_req(FN_WRITE, 4, 0, 0, 32'h1);
    queue_req(FN_ADD, 0, 5, 4, '0);
    queue_req(FN_ADD, 9, 0, 1, '0);
    queue_req(FN_WRITE, 3, 0, 0, 32'h1234_5678);
    wait_idle();
    write_size(SIZE_W'(0));
    queue_req(FN_READ, 0, 0, 0, '0);
    queue_req(FN_WRITE, 0, 0, 0, 32'h5);
    queue_req(FN_UNDEF, 0, 0, 0, '0);
    wait_idle();
    write_size(SIZE_W'(2047));
    queue_req(FN_READ, 1023, 0, 0, '0);
    queue_req(FN_ADD, 1023, 3, 1022, '0);
    queue_req(FN_READ, 1022, 0, 0, '0);
    wait_idle();
    write_size(SIZE_W'(1));
    queue_req(FN_READ, 0, 0, 0, '0);
    queue_req(FN_WRITE, 1, 0, 0, 32'h9);
    wait_idle();

    seg_sizes = '{1024, 2047, 24, 1, 0, 1024, 3, 1024};
    seg_items = '{185, 185, 185, 185, 40, 185, 185, 185};
    seg_sizes[5] = $urandom_range(2, 1024);
    for (int seg = 0; seg < 8; seg++) begin
      write_size(SIZE_W'(seg_sizes[seg]));
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int n = 0; n < seg_items[seg]; n++) queue_random_req();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS checked_word_memory_with_add_unit");
    end else begin
      $display("FAIL checked_word_memory_with_add_unit");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL checked_word_memory_with_add_unit");
    $finish;
  end

endmodule
